// ----- design/assert_macros.svh -----
// Assertion macros for the point-in-polygon top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising clk, idle in reset.
`define PIP_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked on every rising clk, idle in reset.
`define PIP_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- design/pip_pkg.sv -----
// Shared constants and types for the point-in-polygon test unit.
`timescale 1ns / 1ps
package pip_pkg;
	localparam int MAX_VERTICES_DEF = 16;
	localparam int COORD_WIDTH_DEF  = 32;
	localparam int CFG_WIDTH        = 5;
	localparam int IDX_WIDTH        = 4;
	localparam int VCOUNT_RESET     = 3;

	typedef enum logic {
		MODE_VERTEX = 1'b0,
		MODE_QUERY  = 1'b1
	} pip_mode_t;

	// One edge slot travelling down the pipeline.
	typedef struct packed {
		logic valid;   // slot carries a vertex read
		logic edge_v;  // a previous vertex exists, so this slot closes an edge
		logic last;    // final slot of the query
	} pip_tok_t;
endpackage

// ----- design/pip_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module pip_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

// ----- design/pip_seq.sv -----
// Command acceptance, vertex write decode and per-query vertex read sequencer.
`timescale 1ns / 1ps
module pip_seq #(
	parameter int MAX_VERTICES = pip_pkg::MAX_VERTICES_DEF,
	parameter int COORD_WIDTH  = pip_pkg::COORD_WIDTH_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	input  pip_pkg::pip_mode_t                 mode,
	input  logic [pip_pkg::IDX_WIDTH-1:0]      vertex_index,
	input  logic signed [COORD_WIDTH-1:0]      coord_x,
	input  logic signed [COORD_WIDTH-1:0]      coord_y,
	input  logic [$clog2(MAX_VERTICES+1)-1:0]  active_cnt,
	input  logic                               result_done,
	output logic                               busy,
	output logic                               ram_we,
	output logic [$clog2(MAX_VERTICES)-1:0]    ram_waddr,
	output logic [$clog2(MAX_VERTICES)-1:0]    ram_raddr,
	output logic signed [COORD_WIDTH-1:0]      point_x,
	output logic signed [COORD_WIDTH-1:0]      point_y,
	output pip_pkg::pip_tok_t                  tok
);
	import pip_pkg::*;

	localparam int AW   = $clog2(MAX_VERTICES);
	localparam int CNTW = $clog2(MAX_VERTICES + 1);
	localparam int CMPW = (CNTW > IDX_WIDTH) ? CNTW : IDX_WIDTH;

	logic            busy_q;
	logic            issuing_q;
	logic [CNTW-1:0] step_q;
	logic            busy_now;
	logic            accept;
	logic            at_last;

	// the result cycle already frees the unit
	assign busy_now = busy_q && !result_done;
	assign accept   = start && !busy_now;
	assign at_last  = (step_q == active_cnt);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q    <= 1'b0;
			issuing_q <= 1'b0;
			step_q    <= '0;
		end else if (accept && mode == MODE_QUERY) begin
			busy_q    <= 1'b1;
			issuing_q <= 1'b1;
			step_q    <= '0;
		end else if (result_done) begin
			busy_q <= 1'b0;
		end else if (issuing_q) begin
			if (at_last) begin
				issuing_q <= 1'b0;
			end else begin
				step_q <= step_q + 1'b1;
			end
		end
	end

	// hold the query point for the whole edge sweep
	always_ff @(posedge clk) begin
		if (accept && mode == MODE_QUERY) begin
			point_x <= coord_x;
			point_y <= coord_y;
		end
	end

	// drop vertex writes at or beyond the active count
	assign ram_we    = accept && (mode == MODE_VERTEX)
	                   && (CMPW'(vertex_index) < CMPW'(active_cnt));
	assign ram_waddr = AW'(vertex_index);
	// the closing edge re-reads vertex 0
	assign ram_raddr = at_last ? '0 : step_q[AW-1:0];

	assign tok.valid  = issuing_q;
	assign tok.edge_v = (step_q != '0);
	assign tok.last   = at_last;
	assign busy       = busy_now;
endmodule

// ----- design/pip_edge.sv -----
// Edge crossing pipeline: differences, cross products, compare and parity.
`timescale 1ns / 1ps
module pip_edge #(
	parameter int COORD_WIDTH = pip_pkg::COORD_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  pip_pkg::pip_tok_t             tok_in,
	input  logic [2*COORD_WIDTH-1:0]      vertex_rd,
	input  logic signed [COORD_WIDTH-1:0] point_x,
	input  logic signed [COORD_WIDTH-1:0] point_y,
	output logic                          done,
	output logic                          in_poly
);
	import pip_pkg::*;

	localparam int W  = COORD_WIDTH;
	localparam int DW = W + 1;
	localparam int PW = 2 * DW;

	pip_tok_t tok_s1, tok_s2, tok_s3;

	logic signed [W-1:0]  bx, by, ax_q, ay_q;
	logic                 straddle;
	logic signed [DW-1:0] dxp_s2, dy_s2, dx_s2, dyp_s2;
	logic                 cand_s2, cand_s3, dypos_s3;
	logic signed [PW-1:0] lhs_s3, rhs_s3;
	logic                 hit;
	logic                 parity_q, done_q, inside_q;

	assign bx = vertex_rd[2*W-1:W];
	assign by = vertex_rd[W-1:0];

	// point's y strictly below exactly one end of the edge
	assign straddle = (point_y < ay_q) != (point_y < by);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_s1 <= '0;
			tok_s2 <= '0;
			tok_s3 <= '0;
		end else begin
			tok_s1 <= tok_in;
			tok_s2 <= tok_s1;
			tok_s3 <= tok_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (tok_s1.valid) begin
			ax_q <= bx;
			ay_q <= by;
		end
		cand_s2 <= tok_s1.edge_v && straddle;
		dxp_s2  <= DW'(point_x) - DW'(ax_q);
		dy_s2   <= DW'(by) - DW'(ay_q);
		dx_s2   <= DW'(bx) - DW'(ax_q);
		dyp_s2  <= DW'(point_y) - DW'(ay_q);

		cand_s3  <= cand_s2;
		dypos_s3 <= !dy_s2[DW-1];
		lhs_s3   <= dxp_s2 * dy_s2;
		rhs_s3   <= dx_s2 * dyp_s2;
	end

	// point left of the crossing, compare flipped for falling edges
	assign hit = cand_s3 && (dypos_s3 ? (lhs_s3 < rhs_s3) : (lhs_s3 > rhs_s3));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			parity_q <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			done_q <= tok_s3.valid && tok_s3.last;
			if (tok_s3.valid) begin
				parity_q <= tok_s3.last ? 1'b0 : (parity_q ^ hit);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (tok_s3.valid && tok_s3.last) begin
			inside_q <= parity_q ^ hit;
		end
	end

	assign done    = done_q;
	assign in_poly = inside_q;
endmodule

// ----- design/point_in_polygon_test_unit.sv -----
// Top level of the even-odd point-in-polygon test unit.
`timescale 1ns / 1ps
`include "assert_macros.svh"
// Usage:
//   Command channel: a beat is taken at a rising clk edge with start high and busy low.
//   mode selects a vertex write (vertex_index, coord_x, coord_y into the table) or a
//   query of the point (coord_x, coord_y). Vertex writes at or beyond the active
//   vertex count are dropped. Coordinates are signed fixed point, COORD_WIDTH bits.
//   Configuration: cfg_wr_en writes cfg_wr_data into the vertex count register at
//   the rising edge; counts above MAX_VERTICES act as MAX_VERTICES.
//   Result channel: done is high for exactly one cycle with inside_res valid; the
//   receiver takes it at the edge ending that cycle and cannot hold it off.
// Timing:
//   A vertex write leaves busy low, so writes can stream one per cycle while no
//   query holds busy high. A query with n active vertices raises busy until its
//   result: n + 1 vertex table reads (one per cycle through the single read port,
//   vertex 0 read again for the closing edge) feed a four-stage edge pipeline
//   (read, differences, products, compare/parity). done rises once the last read
//   has passed that pipeline; busy falls in that same cycle, so the next beat may
//   be taken at the edge that ends the result cycle.
// Reset: arst_n clears control state and sets the vertex count to 3; the vertex
//   table holds no defined value until written.
module point_in_polygon_test_unit #(
	parameter int MAX_VERTICES = pip_pkg::MAX_VERTICES_DEF,
	parameter int COORD_WIDTH  = pip_pkg::COORD_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic                          mode,
	input  logic [pip_pkg::IDX_WIDTH-1:0] vertex_index,
	input  logic signed [COORD_WIDTH-1:0] coord_x,
	input  logic signed [COORD_WIDTH-1:0] coord_y,
	input  logic                          cfg_wr_en,
	input  logic [pip_pkg::CFG_WIDTH-1:0] cfg_wr_data,
	output logic                          done,
	output logic                          inside_res
);
	import pip_pkg::*;

	localparam int AW   = $clog2(MAX_VERTICES);
	localparam int CNTW = $clog2(MAX_VERTICES + 1);
	localparam int CMPW = (CNTW > CFG_WIDTH) ? CNTW : CFG_WIDTH;

	logic [CFG_WIDTH-1:0]   vcount_q;
	logic [CNTW-1:0]        active_cnt;
	logic                   ram_we;
	logic [AW-1:0]          ram_waddr, ram_raddr;
	logic [2*COORD_WIDTH-1:0] ram_rdata;
	logic signed [COORD_WIDTH-1:0] point_x, point_y;
	pip_tok_t               tok;
	logic                   result_done;

	// vertex count register; the user writes it only while idle, the block does not enforce this
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vcount_q <= CFG_WIDTH'(VCOUNT_RESET);
		end else if (cfg_wr_en) begin
			vcount_q <= cfg_wr_data;
		end
	end

	// saturate the count at the table depth
	assign active_cnt = (CMPW'(vcount_q) > CMPW'(MAX_VERTICES))
	                    ? CNTW'(MAX_VERTICES) : CNTW'(vcount_q);

	pip_seq #(
		.MAX_VERTICES (MAX_VERTICES),
		.COORD_WIDTH  (COORD_WIDTH)
	) u_seq (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.mode         (pip_mode_t'(mode)),
		.vertex_index (vertex_index),
		.coord_x      (coord_x),
		.coord_y      (coord_y),
		.active_cnt   (active_cnt),
		.result_done  (result_done),
		.busy         (busy),
		.ram_we       (ram_we),
		.ram_waddr    (ram_waddr),
		.ram_raddr    (ram_raddr),
		.point_x      (point_x),
		.point_y      (point_y),
		.tok          (tok)
	);

	// x in the upper half of a word, y in the lower half
	pip_ram #(
		.WIDTH (2 * COORD_WIDTH),
		.DEPTH (MAX_VERTICES)
	) u_vtx_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata ({coord_x, coord_y}),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	pip_edge #(
		.COORD_WIDTH (COORD_WIDTH)
	) u_edge (
		.clk       (clk),
		.arst_n    (arst_n),
		.tok_in    (tok),
		.vertex_rd (ram_rdata),
		.point_x   (point_x),
		.point_y   (point_y),
		.done      (result_done),
		.in_poly   (inside_res)
	);

	assign done = result_done;

	// a result beat always ends the query, so the unit is free in that cycle
	`PIP_ASSERT_IMP(a_done_frees, done, !busy, "result beat while still busy")
	// a query beat holds the unit busy while the edges are swept
	`PIP_ASSERT_NXT(a_query_busy, start && !busy && (mode == MODE_QUERY), busy,
		"query beat did not raise busy")
	// a vertex write never occupies the unit
	`PIP_ASSERT_NXT(a_write_free, start && !busy && (mode == MODE_VERTEX), !busy,
		"vertex write raised busy")
	// one result beat per query, never two in a row
	`PIP_ASSERT_NXT(a_single_done, done, !done, "result beat repeated")
endmodule

// ----- dv/pip_tb_pkg.sv -----
// Scoreboard that mirrors the vertex table and predicts the parity of each query.
`timescale 1ns / 1ps
package pip_tb_pkg;
	import pip_pkg::*;

	localparam int CROSS_BITS = 2 * COORD_WIDTH_DEF + 4;

	typedef logic signed [COORD_WIDTH_DEF-1:0] coord_t;
	typedef logic signed [CROSS_BITS-1:0]      cross_t;

	class polygon_scoreboard;
		coord_t               vert_x[MAX_VERTICES_DEF];
		coord_t               vert_y[MAX_VERTICES_DEF];
		logic [CFG_WIDTH-1:0] count_reg;
		bit                   inside_due[$];
		int                   mismatches;
		int                   queries;
		int                   inside_seen;
		int                   vertices_stored;

		function new();
			count_reg = CFG_WIDTH'(VCOUNT_RESET);
			foreach (vert_x[i]) begin
				vert_x[i] = '0;
				vert_y[i] = '0;
			end
		endfunction

		// counts past the table size saturate
		function int live_vertices();
			return (count_reg > MAX_VERTICES_DEF) ? MAX_VERTICES_DEF : int'(count_reg);
		endfunction

		function void set_count(logic [CFG_WIDTH-1:0] value);
			count_reg = value;
		endfunction

		// Even-odd ray cast, exact: compare cross products instead of dividing by dy.
		function bit odd_crossings(coord_t px, coord_t py);
			cross_t x1, y1, x2, y2, ex, ey, rise, lhs, rhs;
			int     n, j;
			bit     parity;
			n = live_vertices();
			parity = 1'b0;
			ex = px;
			ey = py;
			for (int i = 0; i < n; i++) begin
				j = (i + 1 == n) ? 0 : i + 1;
				// a horizontal edge never straddles, so it drops out here
				if ((py < vert_y[i]) != (py < vert_y[j])) begin
					x1 = vert_x[i];
					y1 = vert_y[i];
					x2 = vert_x[j];
					y2 = vert_y[j];
					rise = y2 - y1;
					lhs = (ex - x1) * rise;
					rhs = (x2 - x1) * (ey - y1);
					if ((rise > 0 && lhs < rhs) || (rise < 0 && lhs > rhs))
						parity = ~parity;
				end
			end
			return parity;
		endfunction

		function void note_beat(pip_mode_t kind, logic [IDX_WIDTH-1:0] slot, coord_t cx,
				coord_t cy);
			if (kind == MODE_VERTEX) begin
				if (int'(slot) < live_vertices()) begin
					vert_x[slot] = cx;
					vert_y[slot] = cy;
					vertices_stored++;
				end
			end else begin
				inside_due = {inside_due, odd_crossings(cx, cy)};
				queries++;
			end
		endfunction

		function void check_result(logic got);
			bit want;
			if (inside_due.size() == 0) begin
				$error("inside_res: unexpected result %b with no query outstanding", got);
				mismatches++;
			end else begin
				want = inside_due.pop_front();
				if (want)
					inside_seen++;
				if (got !== want) begin
					$error("inside_res: expected %0b, actual %0b", want, got);
					mismatches++;
				end
			end
		endfunction
	endclass
endpackage

// ----- dv/tb_point_in_polygon_test_unit.sv -----
// Self-checking testbench for the point-in-polygon test unit.
`timescale 1ns / 1ps
module tb_point_in_polygon_test_unit;
	import pip_pkg::*;
	import pip_tb_pkg::*;

	localparam int CYCLE_LIMIT   = 400000;
	// longest query is 16 vertices plus the four-stage edge pipeline; leave margin
	localparam int SETTLE_CYCLES = MAX_VERTICES_DEF + 8;
	localparam int PHASE_ITEMS   = 160;
	localparam int PHASES        = 10;

	localparam coord_t COORD_MIN = 32'h8000_0000;
	localparam coord_t COORD_MAX = 32'h7FFF_FFFF;
	localparam coord_t UNIT      = 32'h0001_0000;

	// how vertices of a fresh polygon are spread
	typedef enum {SHAPE_WIDE, SHAPE_GRID, SHAPE_CLUSTER} shape_t;
	// where a query point is placed relative to the stored polygon
	typedef enum {PROBE_WIDE, PROBE_VERTEX, PROBE_SPAN, PROBE_GRID} probe_t;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 start;
	logic                 busy;
	logic                 mode;
	logic [IDX_WIDTH-1:0] vertex_index;
	coord_t               coord_x;
	coord_t               coord_y;
	logic                 cfg_wr_en;
	logic [CFG_WIDTH-1:0] cfg_wr_data;
	logic                 done;
	logic                 inside_res;

	polygon_scoreboard sb;
	bit                idling;
	shape_t            shape;
	coord_t            hub_x;
	coord_t            hub_y;
	int                cycles;

	logic [CFG_WIDTH-1:0] phase_counts[PHASES] = '{16, 31, 5, 0, 1, 2, 17, 9, 3, 16};

	point_in_polygon_test_unit u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.mode        (mode),
		.vertex_index(vertex_index),
		.coord_x     (coord_x),
		.coord_y     (coord_y),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.done        (done),
		.inside_res  (inside_res)
	);

	always #10 clk = ~clk;

	// Sample everything at the rising edge, before the edge's own updates land:
	// register writes first, then accepted beats, then the result strobe.
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_wr_en)
				sb.set_count(cfg_wr_data);
			if (start && !busy)
				sb.note_beat(pip_mode_t'(mode), vertex_index, coord_x, coord_y);
			if (done)
				sb.check_result(inside_res);
		end
	end

	// Watchdog: a hung block must not hang the run.
	initial begin
		for (cycles = 0; cycles < CYCLE_LIMIT; cycles++)
			@(posedge clk);
		$display("end of test: mismatches");
		$finish;
	end

	function automatic coord_t wide_coord();
		case ($urandom_range(0, 9))
			0:       return COORD_MIN;
			1:       return COORD_MAX;
			2:       return '0;
			3:       return '1;
			default: return coord_t'($urandom());
		endcase
	endfunction

	// small lattice: many shared y values, so plenty of horizontal edges and ties
	function automatic coord_t grid_coord(int steps, int shift);
		return coord_t'((int'($urandom_range(0, 2 * steps)) - steps) <<< shift);
	endfunction

	function automatic coord_t jitter(coord_t base, int reach);
		return base + coord_t'(int'($urandom_range(0, 2 * reach)) - reach);
	endfunction

	function automatic coord_t midpoint(coord_t a, coord_t b);
		longint sum;
		sum = longint'(a) + longint'(b);
		return coord_t'(sum >>> 1);
	endfunction

	function automatic coord_t shape_coord(bit want_y);
		case (shape)
			SHAPE_WIDE: return wide_coord();
			SHAPE_GRID: return grid_coord(4, 16);
			default:    return jitter(want_y ? hub_y : hub_x, 1 << 20);
		endcase
	endfunction

	// Present one beat and hold it until taken. Leave start high so that a
	// back-to-back beat needs no second assignment in the same step.
	task automatic send_beat(input pip_mode_t kind, input logic [IDX_WIDTH-1:0] slot,
			input coord_t cx, input coord_t cy);
		start        <= 1'b1;
		mode         <= kind;
		vertex_index <= slot;
		coord_x      <= cx;
		coord_y      <= cy;
		do @(posedge clk); while (busy);
	endtask

	task automatic hold_off(input int gap);
		start <= 1'b0;
		repeat (gap) @(posedge clk);
	endtask

	task automatic maybe_idle();
		if (idling && $urandom_range(0, 3) == 0)
			hold_off($urandom_range(1, 6));
	endtask

	// Drop start and wait until every outstanding query has answered, then let
	// the pipeline run dry before anything touches the vertex count.
	task automatic settle();
		start <= 1'b0;
		@(posedge clk);
		while (sb.inside_due.size() != 0 || busy)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_count(input logic [CFG_WIDTH-1:0] value);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= value;
		@(posedge clk);
		cfg_wr_en   <= 1'b0;
	endtask

	task automatic new_shape();
		shape = shape_t'($urandom_range(0, 2));
		hub_x = coord_t'($urandom()) >>> 2;
		hub_y = coord_t'($urandom()) >>> 2;
	endtask

	// Fill every live slot in order: a complete, well-formed polygon.
	task automatic write_polygon();
		for (int k = 0; k < sb.live_vertices(); k++) begin
			send_beat(MODE_VERTEX, IDX_WIDTH'(k), shape_coord(1'b0), shape_coord(1'b1));
			maybe_idle();
		end
	endtask

	task automatic send_probe(input probe_t kind);
		int     top, a, b;
		coord_t px, py;
		top = (sb.live_vertices() == 0) ? 0 : sb.live_vertices() - 1;
		a   = $urandom_range(0, top);
		b   = $urandom_range(0, top);
		case (kind)
			PROBE_WIDE: begin
				px = wide_coord();
				py = wide_coord();
			end
			PROBE_VERTEX: begin
				// land on or right next to a vertex, often at exactly its y
				px = jitter(sb.vert_x[a], 2);
				py = $urandom_range(0, 1) ? sb.vert_y[a] : jitter(sb.vert_y[a], 2);
			end
			PROBE_SPAN: begin
				py = midpoint(sb.vert_y[a], sb.vert_y[b]);
				px = jitter(midpoint(sb.vert_x[a], sb.vert_x[b]), 3);
			end
			default: begin
				px = grid_coord(8, 15);
				py = grid_coord(8, 15);
			end
		endcase
		send_beat(MODE_QUERY, IDX_WIDTH'($urandom_range(0, 15)), px, py);
	endtask

	// One setting of the vertex count: load a polygon, then mostly queries,
	// with polygon reloads and stray single-vertex writes (some out of range).
	task automatic run_phase(input logic [CFG_WIDTH-1:0] count_value, input bit quiet);
		int goal, pick;
		settle();
		write_count(count_value);
		idling = !quiet;
		goal = sb.queries + sb.vertices_stored + PHASE_ITEMS;
		new_shape();
		write_polygon();
		while (sb.queries + sb.vertices_stored < goal) begin
			pick = $urandom_range(0, 99);
			if (pick < 8) begin
				new_shape();
				write_polygon();
			end else if (pick < 22) begin
				send_beat(MODE_VERTEX, IDX_WIDTH'($urandom_range(0, 15)), shape_coord(1'b0),
					shape_coord(1'b1));
				maybe_idle();
			end else begin
				send_probe(probe_t'($urandom_range(0, 3)));
				maybe_idle();
			end
		end
	endtask

	initial begin
		sb = new();
		idling = 1'b0;
		shape  = SHAPE_GRID;
		hub_x  = '0;
		hub_y  = '0;
		start        <= 1'b0;
		mode         <= MODE_VERTEX;
		vertex_index <= '0;
		coord_x      <= '0;
		coord_y      <= '0;
		cfg_wr_en    <= 1'b0;
		cfg_wr_data  <= CFG_WIDTH'(VCOUNT_RESET);
		arst_n       <= 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// Right triangle at the reset count of three, bottom edge horizontal.
		send_beat(MODE_VERTEX, 4'd0, '0, '0);
		send_beat(MODE_VERTEX, 4'd1, 16 * UNIT, '0);
		send_beat(MODE_VERTEX, 4'd2, '0, 16 * UNIT);
		send_beat(MODE_QUERY, 4'd0, UNIT, UNIT);
		send_beat(MODE_QUERY, 4'd0, -UNIT, UNIT);
		send_beat(MODE_QUERY, 4'd0, UNIT, '0);
		send_beat(MODE_QUERY, 4'd0, '0, 16 * UNIT);
		send_beat(MODE_QUERY, 4'd0, 8 * UNIT, 8 * UNIT);
		// slots past the count must be dropped
		send_beat(MODE_VERTEX, 4'd7, 5 * UNIT, 5 * UNIT);
		send_beat(MODE_VERTEX, 4'd15, COORD_MIN, COORD_MAX);
		send_beat(MODE_QUERY, 4'd15, UNIT, UNIT);
		settle();

		// Triangle spanning the whole coordinate range.
		send_beat(MODE_VERTEX, 4'd0, COORD_MIN, COORD_MIN);
		send_beat(MODE_VERTEX, 4'd1, COORD_MAX, COORD_MIN);
		send_beat(MODE_VERTEX, 4'd2, '0, COORD_MAX);
		send_beat(MODE_QUERY, 4'd0, '0, '0);
		send_beat(MODE_QUERY, 4'd0, COORD_MAX, COORD_MAX);
		send_beat(MODE_QUERY, 4'd0, COORD_MIN, COORD_MIN);
		send_beat(MODE_QUERY, 4'd0, COORD_MIN, '0);
		send_beat(MODE_QUERY, 4'd0, '1, '1);
		send_beat(MODE_QUERY, 4'd0, COORD_MAX, COORD_MIN + 1);

		// Degenerate counts: no edges, or too few vertices for odd parity.
		for (int c = 0; c < 3; c++) begin
			settle();
			write_count(CFG_WIDTH'(c));
			send_beat(MODE_QUERY, 4'd0, '1, '1);
		end

		// The first phase runs at sixteen, so every slot is loaded before any
		// later count reads it.
		for (int p = 0; p < PHASES; p++)
			run_phase(phase_counts[p], p == PHASES - 1);
		settle();

		$display("Ran %0d queries (%0d inside) and %0d stored vertex writes.",
			sb.queries, sb.inside_seen, sb.vertices_stored);
		$display("Counts 0 to 31 incl. saturation; wide, grid and clustered polygons.");
		if (sb.mismatches == 0 && sb.inside_due.size() == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end
endmodule
